@@ rtl/tdr_pkg.sv @@
// Types and constants shared by the tracked device RSSI table.
// Holds the item structs, the slot record, the controller states and its commands.
package tdr_pkg;

    typedef struct packed {
        logic [1:0]         action;
        logic               source;
        logic [47:0]        mac_address;
        logic [3:0]         vendor_code;
        logic               phone_flag;
        logic signed [7:0]  rssi_sample;
        logic               connected;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         slot_index;
        logic [15:0]        device_id;
        logic signed [7:0]  median_rssi;
        logic signed [15:0] smoothed_rssi_q8;
        logic [3:0]         stored_vendor;
        logic               stored_phone;
        logic [5:0]         expired_count;
    } t_out_item;

    typedef struct packed {
        logic [47:0]        mac;
        logic [15:0]        id;
        logic               source;
        logic [3:0]         vendor;
        logic               phone;
        logic               conn;
        logic [2:0]         fill;
        logic [2:0]         nxt;
        logic signed [15:0] ema;
        logic               ema_vld;
        logic [31:0]        last_seen;
    } t_slot_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_SCAN_END,
        S_SEL,
        S_LOAD,
        S_MED,
        S_EMA,
        S_WRITE,
        S_EXP_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic hash_init;
        logic hash_step;
        logic scan_clr;
        logic rd_issue;
        logic rd_sel;
        logic build;
        logic med;
        logic ema;
        logic commit;
        logic exp_out;
    } t_dp_cmd;

    typedef struct packed {
        logic hash_done;
        logic is_expire;
        logic out_free;
    } t_dp_stat;

    localparam logic [31:0] FNV_BASIS  = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME  = 32'h01000193;
    localparam logic [3:0]  HASH_STEPS = 4'd10;
    localparam logic [3:0]  SALT_BYTES = 4'd4;
    localparam logic [3:0]  HASH_LAST  = 4'd9;

    localparam logic signed [8:0] ALPHA_NUM  = 9'sd102;
    localparam logic signed [8:0] ALPHA_REST = 9'sd154;

    localparam logic [1:0] CFG_ID_SALT  = 2'd0;
    localparam logic [1:0] CFG_BLE_TMO  = 2'd1;
    localparam logic [1:0] CFG_WIFI_TMO = 2'd2;

    localparam logic [31:0] BLE_TMO_RST  = 32'd30000;
    localparam logic [31:0] WIFI_TMO_RST = 32'd180000;

    localparam logic [1:0] ACT_OBSERVE = 2'd0;
    localparam logic [1:0] ACT_TOUCH   = 2'd1;
    localparam logic [1:0] ACT_EXPIRE  = 2'd2;

    localparam logic [2:0] STAT_HIT      = 3'd0;
    localparam logic [2:0] STAT_NEW_FREE = 3'd1;
    localparam logic [2:0] STAT_NEW_OLD  = 3'd2;
    localparam logic [2:0] STAT_TOUCH    = 3'd3;
    localparam logic [2:0] STAT_EXPIRE   = 3'd4;

    localparam logic [5:0] EXP_CNT_MAX = 6'd63;

endpackage

@@ rtl/tracked_device_rssi_table_core.sv @@
// Tracked radio device table with median and EMA RSSI filter, one result per item.
// Top level; depends on tdr_pkg, tdr_ctrl, tdr_dp and tdr_ram.
// A lookup item passes through these steps after its accept: the iterative ten-byte
// FNV-1a hash and its done check, a scan over every slot of the slot record memory,
// a state to settle the scan, then select, load, median, EMA and write-back of the
// chosen slot. An expire item skips the slot update. Items are handled one at a
// time; the last step waits only while the output register still holds an
// unaccepted result, and a finished result waits there while the next item is
// already taken. No clearing pass is needed after reset.
module tracked_device_rssi_table_core #(
    parameter int SLOT_COUNT    = 32,
    parameter int HISTORY_DEPTH = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tdr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tdr_pkg::t_out_item o_out_item
);
    import tdr_pkg::*;

    t_dp_cmd                       cmd;
    t_dp_stat                      stat;
    logic [$clog2(SLOT_COUNT)-1:0] idx;

    tdr_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_in_stall (o_in_stall)
    );

    tdr_dp #(.SLOT_COUNT(SLOT_COUNT), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

    a_count_only_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != STAT_EXPIRE))
            |-> (o_out_item.expired_count == 6'd0))
        else $error("expired count on a lookup result");

    a_expire_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == STAT_EXPIRE))
            |-> ((o_out_item.slot_index == 5'd0) && (o_out_item.device_id == 16'd0)))
        else $error("expire result carries slot fields");
`endif
endmodule

@@ rtl/tdr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/tdr_ctrl.sv @@
// Controller of the tracked device RSSI table: sequences hash, slot scan and update.
// Depends on tdr_pkg.
module tdr_ctrl #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  tdr_pkg::t_dp_stat             i_stat,
    output tdr_pkg::t_dp_cmd              o_cmd,
    output logic [$clog2(SLOT_COUNT)-1:0] o_idx,
    output logic                          o_in_stall
);
    import tdr_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_idx      = r_cnt;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.hash_init = 1'b1;
                    n_state         = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.scan_clr = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (r_cnt == IDX_W'(SLOT_COUNT - 1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCAN_END: begin
                n_state = i_stat.is_expire ? S_EXP_OUT : S_SEL;
            end
            S_SEL: begin
                o_cmd.rd_sel = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.build = 1'b1;
                n_state     = S_MED;
            end
            S_MED: begin
                o_cmd.med = 1'b1;
                n_state   = S_EMA;
            end
            S_EMA: begin
                o_cmd.ema = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EXP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.exp_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/tdr_dp.sv @@
// Datapath of the tracked device RSSI table: config, hash, scan, median, EMA, output.
// Depends on tdr_pkg and tdr_ram.
module tdr_dp #(
    parameter int SLOT_COUNT    = 32,
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  tdr_pkg::t_in_item             i_in_item,
    input  tdr_pkg::t_dp_cmd              i_cmd,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_idx,
    output tdr_pkg::t_dp_stat             o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tdr_pkg::t_out_item            o_out_item
);
    import tdr_pkg::*;

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int REC_W   = $bits(t_slot_rec);
    localparam int RING_W  = 8 * HISTORY_DEPTH;
    localparam logic [2:0] HD3 = 3'(HISTORY_DEPTH);

    logic [31:0]             r_salt, r_ble_tmo, r_wifi_tmo;
    t_in_item                r_item;
    logic [31:0]             r_hash;
    logic [3:0]              r_hstep;
    logic [IDX_W-1:0]        r_pidx;
    logic                    r_pvld;
    logic [SLOT_COUNT-1:0]   r_valid;
    logic                    r_hit_fnd, r_free_fnd;
    logic [IDX_W-1:0]        r_hit_idx, r_free_idx, r_best_idx;
    logic [31:0]             r_best_age;
    logic [CNT_W-1:0]        r_exp_cnt;
    logic [IDX_W-1:0]        r_s;
    logic [2:0]              r_status;
    logic                    r_miss;
    t_slot_rec               r_rec;
    logic [HISTORY_DEPTH-1:0][7:0] r_ring;
    logic signed [7:0]       r_med;
    t_out_item               r_out;
    logic                    r_out_vld;

    logic [REC_W-1:0]        rd_rec_bits;
    logic [RING_W-1:0]       rd_ring_bits;
    t_slot_rec               rd_rec;
    logic [HISTORY_DEPTH-1:0][7:0] rd_ring;
    logic [IDX_W-1:0]        raddr, sel_s;
    logic [7:0]              h_byte;
    logic [5:0]              mac_sh;
    logic [15:0]             dev_id;
    logic [31:0]             age, tmo;
    logic                    is_expire, is_touch, out_free;
    t_slot_rec               b_rec;
    logic [HISTORY_DEPTH-1:0][7:0] b_ring;
    logic [2:0]              b_nx;
    logic [2:0]              m_n;
    logic [2:0]              m_rank [HISTORY_DEPTH];
    logic signed [7:0]       m_val;
    logic signed [16:0]      ema_p1;
    logic signed [24:0]      ema_p2, ema_sum;
    logic [IDX_W+4:0]        s_ext;
    logic [CNT_W+5:0]        cnt_ext;
    logic [5:0]              cnt_sat;
    t_out_item               exp_res;

    assign is_expire = (r_item.action >= ACT_EXPIRE);
    assign is_touch  = (r_item.action == ACT_TOUCH);
    assign out_free  = !r_out_vld || !i_out_stall;

    assign o_stat.hash_done = (r_hstep == HASH_STEPS);
    assign o_stat.is_expire = is_expire;
    assign o_stat.out_free  = out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt     <= '0;
            r_ble_tmo  <= BLE_TMO_RST;
            r_wifi_tmo <= WIFI_TMO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ID_SALT:  r_salt     <= i_cfg_data;
                CFG_BLE_TMO:  r_ble_tmo  <= i_cfg_data;
                CFG_WIFI_TMO: r_wifi_tmo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // slot memories
    assign raddr = i_cmd.rd_sel ? sel_s : i_idx;

    tdr_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_s),
        .i_wdata (r_rec),
        .i_raddr (raddr),
        .o_rdata (rd_rec_bits)
    );

    tdr_ram #(.WIDTH(RING_W), .DEPTH(SLOT_COUNT)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_s),
        .i_wdata (r_ring),
        .i_raddr (raddr),
        .o_rdata (rd_ring_bits)
    );

    assign rd_rec  = rd_rec_bits;
    assign rd_ring = rd_ring_bits;

    // hash: salt bytes low first, then MAC bytes high first
    assign mac_sh = {3'(HASH_LAST - r_hstep), 3'b000};
    always_comb begin
        if (r_hstep < SALT_BYTES) begin
            h_byte = 8'(r_salt >> {r_hstep[1:0], 3'b000});
        end else begin
            h_byte = 8'(r_item.mac_address >> mac_sh);
        end
    end
    assign dev_id = r_hash[15:0] ^ r_hash[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hstep <= '0;
        end else if (i_cmd.hash_init) begin
            r_hstep <= '0;
        end else if (i_cmd.hash_step) begin
            r_hstep <= r_hstep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.hash_init) begin
            r_hash <= FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            r_hash <= (r_hash ^ {24'b0, h_byte}) * FNV_PRIME;
        end
    end

    // scan
    assign age = r_item.now_ms - rd_rec.last_seen;
    assign tmo = rd_rec.source ? r_wifi_tmo : r_ble_tmo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.rd_issue;
        end
        r_pidx <= i_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            r_valid[r_s] <= 1'b1;
        end else if (r_pvld && is_expire && r_valid[r_pidx] && (age > tmo)) begin
            r_valid[r_pidx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_exp_cnt  <= '0;
        end else if (r_pvld) begin
            if (is_expire) begin
                if (r_valid[r_pidx] && (age > tmo)) begin
                    r_exp_cnt <= r_exp_cnt + 1'b1;
                end
            end else begin
                if (r_valid[r_pidx] && !r_hit_fnd
                        && (rd_rec.mac == r_item.mac_address)) begin
                    r_hit_fnd <= 1'b1;
                    r_hit_idx <= r_pidx;
                end
                if (!r_valid[r_pidx] && !r_free_fnd) begin
                    r_free_fnd <= 1'b1;
                    r_free_idx <= r_pidx;
                end
                if ((r_pidx == '0) || (age > r_best_age)) begin
                    r_best_age <= age;
                    r_best_idx <= r_pidx;
                end
            end
        end
    end

    // slot choice
    assign sel_s = r_hit_fnd ? r_hit_idx : (r_free_fnd ? r_free_idx : r_best_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel) begin
            r_s      <= sel_s;
            r_miss   <= !r_hit_fnd;
            r_status <= r_hit_fnd ? STAT_HIT : (r_free_fnd ? STAT_NEW_FREE : STAT_NEW_OLD);
        end
    end

    // record update
    always_comb begin
        if (r_miss) begin
            b_rec         = '0;
            b_rec.mac     = r_item.mac_address;
            b_rec.id      = dev_id;
            b_rec.source  = r_item.source;
            b_ring        = '0;
        end else begin
            b_rec  = rd_rec;
            b_ring = rd_ring;
        end
        b_rec.conn      = r_item.connected;
        b_rec.last_seen = r_item.now_ms;
        b_nx = (b_rec.nxt >= HD3) ? 3'd0 : b_rec.nxt;
        if (r_item.action == ACT_OBSERVE) begin
            if (r_item.vendor_code != '0) begin
                b_rec.vendor = r_item.vendor_code;
                b_rec.phone  = r_item.phone_flag;
            end
            for (int j = 0; j < HISTORY_DEPTH; j++) begin
                if (b_nx == 3'(j)) begin
                    b_ring[j] = r_item.rssi_sample;
                end
            end
            b_rec.nxt = (b_nx == HD3 - 3'd1) ? 3'd0 : b_nx + 3'd1;
            if (b_rec.fill < HD3) begin
                b_rec.fill = b_rec.fill + 3'd1;
            end
        end
    end

    // median by rank over the filled entries
    assign m_n = (r_rec.fill > HD3) ? HD3 : r_rec.fill;
    always_comb begin
        m_val = '0;
        for (int j = 0; j < HISTORY_DEPTH; j++) begin
            m_rank[j] = '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                if ((3'(k) < m_n) && (($signed(r_ring[k]) < $signed(r_ring[j]))
                        || ((r_ring[k] == r_ring[j]) && (k < j)))) begin
                    m_rank[j] = m_rank[j] + 3'd1;
                end
            end
            if ((3'(j) < m_n) && (m_rank[j] == (m_n >> 1))) begin
                m_val = $signed(r_ring[j]);
            end
        end
    end

    // EMA
    assign ema_p1  = r_med * ALPHA_NUM;
    assign ema_p2  = r_rec.ema * ALPHA_REST;
    assign ema_sum = $signed({ema_p1, 8'h00}) + ema_p2 + 25'sd128;

    always_ff @(posedge i_clk) begin
        if (i_cmd.build) begin
            r_rec  <= b_rec;
            r_ring <= b_ring;
        end else if (i_cmd.ema && (r_item.action == ACT_OBSERVE)) begin
            r_rec.ema_vld <= 1'b1;
            r_rec.ema     <= r_rec.ema_vld ? ema_sum[23:8] : {r_med, 8'h00};
        end
        if (i_cmd.med) begin
            r_med <= m_val;
        end
    end

    // output register
    assign s_ext   = {5'b0, r_s};
    assign cnt_ext = {6'b0, r_exp_cnt};
    assign cnt_sat = (cnt_ext > {CNT_W'(0), EXP_CNT_MAX}) ? EXP_CNT_MAX : cnt_ext[5:0];

    always_comb begin
        exp_res               = '0;
        exp_res.status        = STAT_EXPIRE;
        exp_res.expired_count = cnt_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit || i_cmd.exp_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.status           <= is_touch ? STAT_TOUCH : r_status;
            r_out.slot_index       <= s_ext[4:0];
            r_out.device_id        <= r_rec.id;
            r_out.median_rssi      <= r_med;
            r_out.smoothed_rssi_q8 <= r_rec.ema_vld ? r_rec.ema : 16'sd0;
            r_out.stored_vendor    <= r_rec.vendor;
            r_out.stored_phone     <= r_rec.phone;
            r_out.expired_count    <= '0;
        end else if (i_cmd.exp_out) begin
            r_out <= exp_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
endmodule

@@ tb/tracked_device_rssi_table_core_tb.sv @@
// Testbench for tracked_device_rssi_table_core: random and directed observe, touch and expire items.
// Depends on tdr_pkg; predicts each result with its own model of the slot table.
`timescale 1ns / 1ps

module tracked_device_rssi_table_core_tb;
    import tdr_pkg::*;

    localparam int NSLOT = 32;
    localparam int HDEPTH = 5;
    localparam int CYCLE_LIMIT = 800000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    tracked_device_rssi_table_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] salt_r, ble_tmo_r, wifi_tmo_r;
    bit          tbl_valid [NSLOT];
    logic [47:0] tbl_mac [NSLOT];
    logic [15:0] tbl_id [NSLOT];
    bit          tbl_src [NSLOT];
    logic [3:0]  tbl_vendor [NSLOT];
    bit          tbl_phone [NSLOT];
    byte         tbl_ring [NSLOT][HDEPTH];
    int          tbl_fill [NSLOT];
    int          tbl_next [NSLOT];
    int          tbl_ema [NSLOT];
    bit          tbl_ema_ok [NSLOT];
    logic [31:0] tbl_seen [NSLOT];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int        errors = 0;
    int        cycles = 0;

    function automatic logic [15:0] device_hash(logic [47:0] mac);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < 4; i++) h = (h ^ ((salt_r >> (8 * i)) & 32'hFF)) * FNV_PRIME;
        for (int i = 5; i >= 0; i--) h = (h ^ {24'd0, mac[8 * i +: 8]}) * FNV_PRIME;
        return h[15:0] ^ h[31:16];
    endfunction

    function automatic byte history_median(int s);
        byte tmp [HDEPTH];
        byte key;
        int  n;
        int  j;
        n = tbl_fill[s];
        if (n == 0) return 0;
        for (int i = 0; i < n; i++) tmp[i] = tbl_ring[s][i];
        for (int i = 1; i < n; i++) begin
            key = tmp[i];
            j = i - 1;
            while (j >= 0 && tmp[j] > key) begin
                tmp[j + 1] = tmp[j];
                j--;
            end
            tmp[j + 1] = key;
        end
        return tmp[n / 2];
    endfunction

    function automatic t_out_item table_update(t_in_item it);
        t_out_item   r;
        int          s;
        int          freed;
        int          sum;
        logic [31:0] tmo, best, age;
        byte         med;
        r = '0;
        if (it.action == ACT_EXPIRE || it.action == 2'd3) begin
            freed = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!tbl_valid[i]) continue;
                tmo = tbl_src[i] ? wifi_tmo_r : ble_tmo_r;
                if (it.now_ms - tbl_seen[i] > tmo) begin
                    tbl_valid[i] = 0;
                    freed++;
                end
            end
            r.status = STAT_EXPIRE;
            r.expired_count = 6'(freed);
            return r;
        end
        s = -1;
        r.status = STAT_HIT;
        for (int i = 0; i < NSLOT; i++)
            if (s < 0 && tbl_valid[i] && tbl_mac[i] == it.mac_address) s = i;
        if (s < 0) begin
            r.status = STAT_NEW_FREE;
            for (int i = 0; i < NSLOT; i++) if (s < 0 && !tbl_valid[i]) s = i;
            if (s < 0) begin
                r.status = STAT_NEW_OLD;
                s = 0;
                best = it.now_ms - tbl_seen[0];
                for (int i = 1; i < NSLOT; i++) begin
                    age = it.now_ms - tbl_seen[i];
                    if (age > best) begin
                        best = age;
                        s = i;
                    end
                end
            end
            tbl_valid[s] = 1;
            tbl_mac[s] = it.mac_address;
            tbl_id[s] = device_hash(it.mac_address);
            tbl_src[s] = it.source;
            tbl_vendor[s] = 0;
            tbl_phone[s] = 0;
            for (int k = 0; k < HDEPTH; k++) tbl_ring[s][k] = 0;
            tbl_fill[s] = 0;
            tbl_next[s] = 0;
            tbl_ema[s] = 0;
            tbl_ema_ok[s] = 0;
        end
        tbl_seen[s] = it.now_ms;
        if (it.action == ACT_TOUCH) begin
            r.status = STAT_TOUCH;
            med = history_median(s);
        end else begin
            if (it.vendor_code != 0) begin
                tbl_vendor[s] = it.vendor_code;
                tbl_phone[s] = it.phone_flag;
            end
            tbl_ring[s][tbl_next[s]] = it.rssi_sample;
            tbl_next[s] = (tbl_next[s] + 1) % HDEPTH;
            if (tbl_fill[s] < HDEPTH) tbl_fill[s]++;
            med = history_median(s);
            if (!tbl_ema_ok[s]) begin
                tbl_ema[s] = int'(med) * 256;
                tbl_ema_ok[s] = 1;
            end else begin
                sum = 102 * int'(med) * 256 + 154 * tbl_ema[s] + 128;
                tbl_ema[s] = sum >>> 8;
            end
        end
        r.slot_index = 5'(s);
        r.device_id = tbl_id[s];
        r.median_rssi = med;
        r.smoothed_rssi_q8 = tbl_ema_ok[s] ? tbl_ema[s][15:0] : 16'd0;
        r.stored_vendor = tbl_vendor[s];
        r.stored_phone = tbl_phone[s];
        return r;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    bit in_taken = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(table_update(pending_items.pop_front()));
            in_taken = 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !in_taken)) begin
        end else begin
            in_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_item <= pending_items[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: one of four stall modes, drawn anew at random
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2: i_out_stall <= ($urandom_range(0, 9) < 8);
            default: i_out_stall <= ((cycles / 37) % 2 == 1);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_out_item);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.status !== o_out_item.status)
                    $display("%0t status exp %0d got %0d", $time, e.status, o_out_item.status);
                if (e.slot_index !== o_out_item.slot_index)
                    $display("%0t slot exp %0d got %0d", $time, e.slot_index,
                             o_out_item.slot_index);
                if (e.device_id !== o_out_item.device_id)
                    $display("%0t id exp %h got %h", $time, e.device_id, o_out_item.device_id);
                if (e.median_rssi !== o_out_item.median_rssi)
                    $display("%0t median exp %0d got %0d", $time, e.median_rssi,
                             o_out_item.median_rssi);
                if (e.smoothed_rssi_q8 !== o_out_item.smoothed_rssi_q8)
                    $display("%0t ema exp %0d got %0d", $time, e.smoothed_rssi_q8,
                             o_out_item.smoothed_rssi_q8);
                if (e.stored_vendor !== o_out_item.stored_vendor)
                    $display("%0t vendor exp %0d got %0d", $time, e.stored_vendor,
                             o_out_item.stored_vendor);
                if (e.stored_phone !== o_out_item.stored_phone)
                    $display("%0t phone exp %0d got %0d", $time, e.stored_phone,
                             o_out_item.stored_phone);
                if (e.expired_count !== o_out_item.expired_count)
                    $display("%0t expired exp %0d got %0d", $time, e.expired_count,
                             o_out_item.expired_count);
                if (e !== o_out_item) errors++;
            end
        end
    end

    logic [31:0] now_t;
    logic [47:0] mac_pool [40];

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_ID_SALT) salt_r = val;
        else if (idx == CFG_BLE_TMO) ble_tmo_r = val;
        else if (idx == CFG_WIFI_TMO) wifi_tmo_r = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_item(logic [1:0] act, logic [47:0] mac, byte rssi,
                            logic [3:0] vend, bit ph, bit src);
        t_in_item it;
        it.action = act;
        it.source = src;
        it.mac_address = mac;
        it.vendor_code = vend;
        it.phone_flag = ph;
        it.rssi_sample = rssi;
        it.connected = 1'($urandom_range(0, 1));
        it.now_ms = now_t;
        pending_items.push_back(it);
    endtask

    task automatic add_random(int count);
        int       pick;
        logic [1:0] act;
        logic [47:0] mac;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            act = pick < 62 ? ACT_OBSERVE : pick < 84 ? ACT_TOUCH :
                  pick < 96 ? ACT_EXPIRE : 2'd3;
            mac = ($urandom_range(0, 3) == 0) ? 48'({$urandom(), $urandom()} >> 16)
                                              : mac_pool[$urandom_range(0, 39)];
            case ($urandom_range(0, 9))
                0: now_t = now_t + $urandom();
                1, 2: ;
                default: now_t = now_t + $urandom_range(0, 4000);
            endcase
            add_item(act, mac, byte'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        salt_r = 32'd0;
        ble_tmo_r = BLE_TMO_RST;
        wifi_tmo_r = WIFI_TMO_RST;
        for (int s = 0; s < NSLOT; s++) tbl_valid[s] = 0;
        for (int i = 0; i < 40; i++) mac_pool[i] = 48'({$urandom(), $urandom()} >> 16);
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        now_t = 32'd100;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset timeouts and salt in force
        add_item(ACT_TOUCH, 48'h0, 8'sd0, 4'd0, 1'b0, 1'b0);
        add_item(ACT_OBSERVE, 48'h0, -8'sd128, 4'd15, 1'b1, 1'b0);
        add_item(ACT_OBSERVE, 48'hFFFF_FFFF_FFFF, 8'sd127, 4'd0, 1'b1, 1'b1);
        add_item(ACT_OBSERVE, 48'h0, 8'sd127, 4'd0, 1'b0, 1'b0);
        add_item(ACT_OBSERVE, 48'h0, 8'sd5, 4'd3, 1'b0, 1'b0);
        add_item(ACT_OBSERVE, 48'h0, -8'sd7, 4'd0, 1'b1, 1'b0);
        add_item(ACT_OBSERVE, 48'h0, 8'sd100, 4'd0, 1'b1, 1'b0);
        add_item(ACT_OBSERVE, 48'h0, -8'sd1, 4'd0, 1'b1, 1'b0);
        add_item(ACT_TOUCH, 48'h0, 8'sd0, 4'd0, 1'b0, 1'b0);
        add_item(ACT_TOUCH, 48'hFFFF_FFFF_FFFF, 8'sd0, 4'd0, 1'b0, 1'b1);
        now_t = now_t + 30001;
        add_item(ACT_EXPIRE, 48'h0, 8'sd0, 4'd0, 1'b0, 1'b0);
        now_t = now_t + 150000;
        add_item(2'd3, 48'h0, 8'sd0, 4'd0, 1'b0, 1'b0);
        for (int i = 0; i < 34; i++) begin
            now_t = now_t + ((i % 3 == 0) ? 0 : 10);
            add_item(ACT_OBSERVE, 48'h5555_0000_0000 + i, byte'(i * 7), 4'(i), 1'b1, i[0]);
        end
        now_t = now_t + 10000;
        add_random(200);
        drain();

        write_reg(CFG_ID_SALT, 32'hFFFF_FFFF);
        write_reg(CFG_BLE_TMO, 32'd0);
        write_reg(CFG_WIFI_TMO, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'h1234_5678);
        now_t = 32'hFFFF_F000;
        add_random(250);
        drain();

        write_reg(CFG_ID_SALT, $urandom());
        write_reg(CFG_BLE_TMO, 32'd500);
        write_reg(CFG_WIFI_TMO, 32'd3000);
        add_random(250);
        drain();

        write_reg(CFG_ID_SALT, $urandom());
        write_reg(CFG_BLE_TMO, 32'hFFFF_FFFF);
        write_reg(CFG_WIFI_TMO, 32'd0);
        add_random(250);
        drain();

        write_reg(CFG_ID_SALT, 32'd0);
        write_reg(CFG_BLE_TMO, 32'd30000);
        write_reg(CFG_WIFI_TMO, 32'd180000);
        add_random(250);
        drain();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
